### hw/rtl/stack_pop_to_match_macros.svh
// Assertion macros for the key stack block.
`ifndef STACK_POP_TO_MATCH_MACROS_SVH
`define STACK_POP_TO_MATCH_MACROS_SVH

`ifndef SYNTHESIS

`define SPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define SPM_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) else $error(msg);

`else

`define SPM_ASSERT(lbl, clk, rstn, prop, msg)

`define SPM_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)

`endif

`endif

### hw/rtl/spm_pkg.sv
// Shared constants and types of the key stack block.
`default_nettype none

package spm_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int KEY_W       = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OUT_W       = ((KEY_W + 3 + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_TOPLD,
        ST_EMIT
    } spm_state_t;

endpackage

`default_nettype wire

### hw/rtl/stack_pop_to_match.sv
// Top level of the key stack with unwind-to-key pop.
// A push is answered in the cycle after the transaction. A pop reads the stack memory
// one entry per cycle from the top downward through its single read port: an empty stack
// answers in the cycle after the transaction; otherwise the search state compares entries
// (the match and those above it, or all of them when the key is absent), the top-load
// state fetches the new top after a match that leaves entries behind, and the emit state
// loads the result register once it is free. One item is in work at a time; the result
// register lets the next transaction in while it is being drained.
`default_nettype none

module stack_pop_to_match (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [spm_pkg::KEY_W-1:0] s_axis_tdata,  // name_key
    input  wire logic                      s_axis_tuser,  // operation
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [spm_pkg::OUT_W-1:0] m_axis_tdata   // top_key, is_empty, not_found,
                                                          // overflow, zero fill
);

    spm_pkg::spm_state_t state_reg, state_next;

    logic [spm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [spm_pkg::ADDR_W-1:0] pos_reg, pos_next;
    logic [spm_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [spm_pkg::KEY_W-1:0]  top_reg, top_next;
    logic                       nf_reg, nf_next;

    logic                       out_valid_reg, out_valid_next;
    logic [spm_pkg::KEY_W-1:0]  out_top_reg, out_top_next;
    logic                       out_empty_reg, out_empty_next;
    logic                       out_nf_reg, out_nf_next;
    logic                       out_ov_reg, out_ov_next;

    logic                       wr_en;
    logic [spm_pkg::ADDR_W-1:0] wr_addr;
    logic                       rd_en;
    logic [spm_pkg::ADDR_W-1:0] rd_addr;
    logic [spm_pkg::KEY_W-1:0]  rd_data;

    logic                       out_free;
    logic                       in_fire;
    logic [spm_pkg::CNT_W-1:0]  cnt_m1;
    logic [spm_pkg::ADDR_W-1:0] pos_m1;
    logic [spm_pkg::CNT_W-1:0]  pos_ext;
    logic                       hit;

    spm_ram #(
        .WIDTH (spm_pkg::KEY_W),
        .DEPTH (spm_pkg::STACK_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == spm_pkg::ST_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cnt_m1        = cnt_reg - spm_pkg::CNT_W'(1);
    assign pos_m1        = pos_reg - spm_pkg::ADDR_W'(1);
    assign pos_ext       = {{(spm_pkg::CNT_W - spm_pkg::ADDR_W){1'b0}}, pos_reg};
    assign hit           = (rd_data == key_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(spm_pkg::OUT_W - spm_pkg::KEY_W - 3){1'b0}},
                            out_ov_reg, out_nf_reg, out_empty_reg, out_top_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spm_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        top_reg       <= top_next;
        nf_reg        <= nf_next;
        out_top_reg   <= out_top_next;
        out_empty_reg <= out_empty_next;
        out_nf_reg    <= out_nf_next;
        out_ov_reg    <= out_ov_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        top_next       = top_reg;
        nf_next        = nf_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_top_next   = out_top_reg;
        out_empty_next = out_empty_reg;
        out_nf_next    = out_nf_reg;
        out_ov_next    = out_ov_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[spm_pkg::ADDR_W-1:0];
        rd_en          = 1'b0;
        rd_addr        = pos_m1;

        case (state_reg)
            spm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == spm_pkg::OP_PUSH)
                    begin
                        out_valid_next = 1'b1;
                        out_nf_next    = 1'b0;
                        if (cnt_reg == spm_pkg::FULL_COUNT)
                        begin
                            out_ov_next    = 1'b1;
                            out_top_next   = top_reg;
                            out_empty_next = 1'b0;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            cnt_next       = cnt_reg + spm_pkg::CNT_W'(1);
                            top_next       = s_axis_tdata;
                            out_ov_next    = 1'b0;
                            out_top_next   = s_axis_tdata;
                            out_empty_next = 1'b0;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_top_next   = '0;
                        out_empty_next = 1'b1;
                        out_nf_next    = 1'b1;
                        out_ov_next    = 1'b0;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = cnt_m1[spm_pkg::ADDR_W-1:0];
                        pos_next   = cnt_m1[spm_pkg::ADDR_W-1:0];
                        key_next   = s_axis_tdata;
                        state_next = spm_pkg::ST_SEARCH;
                    end
                end
            end

            spm_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    cnt_next = pos_ext;
                    nf_next  = 1'b0;
                    if (pos_reg == '0)
                    begin
                        state_next = spm_pkg::ST_EMIT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = spm_pkg::ST_TOPLD;
                    end
                end
                else if (pos_reg == '0)
                begin
                    nf_next    = 1'b1;
                    state_next = spm_pkg::ST_EMIT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    pos_next = pos_m1;
                end
            end

            spm_pkg::ST_TOPLD:
            begin
                top_next   = rd_data;
                state_next = spm_pkg::ST_EMIT;
            end

            spm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_nf_next    = nf_reg;
                    out_ov_next    = 1'b0;
                    out_empty_next = (cnt_reg == '0);
                    out_top_next   = (cnt_reg == '0) ? '0 : top_reg;
                    state_next     = spm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = spm_pkg::ST_IDLE;
            end
        endcase
    end

    `include "stack_pop_to_match_macros.svh"

    `SPM_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= spm_pkg::FULL_COUNT,
                "entry count above depth")
    `SPM_ASSERT(a_pos_below, clk, rst_n,
                (state_reg != spm_pkg::ST_SEARCH) || (pos_ext < cnt_reg), "search beyond top")
    `SPM_ASSERT_NEXT(a_full_hold, clk, rst_n,
                     in_fire && (s_axis_tuser == spm_pkg::OP_PUSH) &&
                     (cnt_reg == spm_pkg::FULL_COUNT),
                     $stable(cnt_reg) && out_ov_reg, "push on full stack changed count")
    `SPM_ASSERT(a_flag_excl, clk, rst_n, !out_valid_reg || !(out_nf_reg && out_ov_reg),
                "not_found and overflow together")

endmodule

`default_nettype wire

### hw/rtl/spm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module spm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
